FILE: rtl/core/stft_pkg.sv
// ----------------------------------------------------------------------------
// Sparse transpose package
// Status codes and the command and status groups passed between the
// controller and the datapath of the sparse triplet transpose.
// ----------------------------------------------------------------------------
package stft_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_COL = 2'd1;
  localparam logic [1:0] STATUS_NNZ = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic update;
    logic pfx_step;
    logic sc_rd_trip;
    logic sc_rd_start;
    logic sc_write;
    logic em_rd;
    logic em_load;
    logic err_load;
    logic clear;
  } stft_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_last;
    logic err_any;
    logic pfx_done;
    logic sc_last;
    logic em_last;
    logic out_free;
  } stft_stat_t;

endpackage

FILE: rtl/core/stft_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse transpose controller
// Sequences loading, prefix sum, scatter and emission of one matrix and
// drives the input stall.
// ----------------------------------------------------------------------------
module stft_ctrl
  import stft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  stft_stat_t stat,
  output stft_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_UPDATE,
    S_PREFIX,
    S_SC_TRIP,
    S_SC_START,
    S_SC_WRITE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_ERR_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow the current state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD:     cmd.load_item = item_valid;
      S_UPDATE:   cmd.update = 1'b1;
      S_PREFIX:   cmd.pfx_step = 1'b1;
      S_SC_TRIP:  cmd.sc_rd_trip = 1'b1;
      S_SC_START: cmd.sc_rd_start = 1'b1;
      S_SC_WRITE: cmd.sc_write = 1'b1;
      S_EMIT_RD:  cmd.em_rd = 1'b1;
      S_EMIT_LD: begin
        cmd.em_load = stat.out_free;
        cmd.clear = stat.out_free && stat.em_last;
      end
      S_ERR_OUT: begin
        cmd.err_load = stat.out_free;
        cmd.clear = stat.out_free;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (item_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat.item_last) begin
          state_next = stat.err_any ? S_ERR_OUT : S_PREFIX;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_PREFIX: begin
        if (stat.pfx_done) state_next = S_SC_TRIP;
      end
      S_SC_TRIP:  state_next = S_SC_START;
      S_SC_START: state_next = S_SC_WRITE;
      S_SC_WRITE: state_next = stat.sc_last ? S_EMIT_RD : S_SC_TRIP;
      S_EMIT_RD:  state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        if (stat.out_free) state_next = stat.em_last ? S_LOAD : S_EMIT_RD;
      end
      S_ERR_OUT: begin
        if (stat.out_free) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // State register and registered stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      item_stall <= 1'b0;
    end else begin
      state <= state_next;
      item_stall <= (state_next != S_LOAD);
    end
  end

`ifndef SYNTH
  // At most one command uses the memory ports in a cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_item, cmd.update, cmd.pfx_step, cmd.sc_rd_trip, cmd.sc_rd_start,
              cmd.sc_write, cmd.em_rd, cmd.em_load, cmd.err_load}))
    else $error("stft_ctrl: overlapping commands");

  // The end of a matrix returns to loading.
  assert property (@(posedge clk) disable iff (rst) cmd.clear |=> state == S_LOAD)
    else $error("stft_ctrl: clear did not return to load");

  // An update is always preceded by an accepted word.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> $past(cmd.load_item))
    else $error("stft_ctrl: update without a loaded word");
`endif

endmodule

FILE: rtl/core/stft_dp.sv
// ----------------------------------------------------------------------------
// Sparse transpose datapath
// Triplet store, column tally and start memory, transposed store, counters
// and the output register.
// ----------------------------------------------------------------------------
module stft_dp
  import stft_pkg::*;
#(
  parameter int MAX_NNZ    = 64,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [8:0]         cfg_data,
  input  logic [7:0]         row_index,
  input  logic [7:0]         col_index,
  input  logic signed [31:0] entry_value,
  input  logic               last_in,
  input  stft_cmd_t          cmd,
  output stft_stat_t         stat,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last_out
);

  localparam int NCOLS = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int CW    = (NCOLS > 1) ? $clog2(NCOLS) : 1;
  localparam int PW    = $clog2(NCOLS + 1);
  localparam int IW    = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int NW    = $clog2(MAX_NNZ + 1);
  localparam int SW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int EW    = 16 + SW;
  localparam int LW    = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam logic [LW-1:0] COL_LIMIT_MAX = LW'(MAX_COLS);
  localparam logic [NW-1:0] NNZ_MAX       = NW'(MAX_NNZ);
  localparam logic [PW-1:0] PFX_END       = PW'(NCOLS);

  // Configuration and the word under update.
  logic [8:0]    column_count;
  logic [7:0]    it_row;
  logic [7:0]    it_col;
  logic [SW-1:0] it_val;
  logic          it_last;

  // Column tally and start memory with its valid bits.
  logic [NW-1:0] cnt_mem [NCOLS];
  logic [NCOLS-1:0] cnt_valid;
  logic [NW-1:0] cnt_rd;
  logic          cnt_rd_valid;
  logic          cnt_rd_en;
  logic [CW-1:0] cnt_raddr;
  logic          cnt_wr_en;
  logic [CW-1:0] cnt_waddr;
  logic [NW-1:0] cnt_wdata;

  // Triplet and transposed stores, entries laid out as {first, second, value}.
  logic [EW-1:0] trip_mem [MAX_NNZ];
  logic [EW-1:0] trip_rd;
  logic [EW-1:0] xp_mem [MAX_NNZ];
  logic [EW-1:0] xp_rd;

  // Matrix counters.
  logic [NW-1:0] count;
  logic [1:0]    err;
  logic [1:0]    err_next;
  logic [PW-1:0] pidx;
  logic [PW-1:0] pidx_prev;
  logic [NW-1:0] pos;
  logic [NW-1:0] sidx;
  logic [NW-1:0] eidx;

  logic [LW-1:0] cc_ext;
  logic [LW-1:0] col_lim;
  logic          col_bad;
  logic          full;
  logic          store_ok;
  logic [NW-1:0] tally;
  logic          pfx_rd;
  logic          pfx_wr;
  logic [7:0]    tr_row;
  logic [7:0]    tr_col;
  logic [SW-1:0] tr_val;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 9'd256;
    end else if (cfg_valid) begin
      column_count <= cfg_data;
    end
  end

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_row <= row_index;
      it_col <= col_index;
      it_val <= entry_value[SW-1:0];
      it_last <= last_in;
    end
  end

  // Range checks and the first error of the matrix.
  always_comb begin
    cc_ext = LW'(column_count);
    col_lim = (cc_ext > COL_LIMIT_MAX) ? COL_LIMIT_MAX : cc_ext;
    col_bad = LW'(it_col) >= col_lim;
    full = count >= NNZ_MAX;
    store_ok = cmd.update && !col_bad && !full;
    err_next = err;
    if (err == STATUS_OK) begin
      if (col_bad) begin
        err_next = STATUS_COL;
      end else if (full) begin
        err_next = STATUS_NNZ;
      end
    end
  end

  assign tally = cnt_rd_valid ? cnt_rd : '0;
  assign pfx_rd = cmd.pfx_step && (pidx != PFX_END);
  assign pfx_wr = cmd.pfx_step && (pidx != '0);
  assign pidx_prev = pidx - PW'(1);
  assign tr_row = trip_rd[EW-1 -: 8];
  assign tr_col = trip_rd[EW-9 -: 8];
  assign tr_val = trip_rd[SW-1:0];

  // Tally memory port selection.
  always_comb begin
    cnt_rd_en = cmd.load_item || pfx_rd || cmd.sc_rd_start;
    cnt_raddr = col_index[CW-1:0];
    if (pfx_rd) begin
      cnt_raddr = pidx[CW-1:0];
    end else if (cmd.sc_rd_start) begin
      cnt_raddr = tr_col[CW-1:0];
    end
    cnt_wr_en = store_ok || pfx_wr || cmd.sc_write;
    cnt_waddr = it_col[CW-1:0];
    cnt_wdata = tally + NW'(1);
    if (pfx_wr) begin
      cnt_waddr = pidx_prev[CW-1:0];
      cnt_wdata = pos;
    end else if (cmd.sc_write) begin
      cnt_waddr = tr_col[CW-1:0];
      cnt_wdata = cnt_rd + NW'(1);
    end
  end

  // Tally and start memory.
  always_ff @(posedge clk) begin
    if (cnt_wr_en) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_rd_en) begin
      cnt_rd <= cnt_mem[cnt_raddr];
      cnt_rd_valid <= cnt_valid[cnt_raddr];
    end
  end

  // Valid bits make an untouched column read as zero.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt_valid <= '0;
    end else if (cnt_wr_en) begin
      cnt_valid[cnt_waddr] <= 1'b1;
    end
  end

  // Source triplet store.
  always_ff @(posedge clk) begin
    if (store_ok) begin
      trip_mem[count[IW-1:0]] <= {it_row, it_col, it_val};
    end
    if (cmd.sc_rd_trip) begin
      trip_rd <= trip_mem[sidx[IW-1:0]];
    end
  end

  // Transposed store, written at the column's next slot.
  always_ff @(posedge clk) begin
    if (cmd.sc_write) begin
      xp_mem[cnt_rd[IW-1:0]] <= {tr_col, tr_row, tr_val};
    end
    if (cmd.em_rd) begin
      xp_rd <= xp_mem[eidx[IW-1:0]];
    end
  end

  // Counters for loading, prefix sum, scatter and emission.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      err <= STATUS_OK;
      pidx <= '0;
      pos <= '0;
      sidx <= '0;
      eidx <= '0;
    end else begin
      if (cmd.update) begin
        err <= err_next;
      end
      if (store_ok) begin
        count <= count + NW'(1);
      end
      if (pfx_wr) begin
        pos <= pos + tally;
      end
      if (pfx_rd) begin
        pidx <= pidx + PW'(1);
      end
      if (cmd.sc_write) begin
        sidx <= sidx + NW'(1);
      end
      if (cmd.em_load) begin
        eidx <= eidx + NW'(1);
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat.item_last = it_last;
    stat.err_any = (err_next != STATUS_OK);
    stat.pfx_done = (pidx == PFX_END);
    stat.sc_last = ((sidx + NW'(1)) == count);
    stat.em_last = ((eidx + NW'(1)) == count);
    stat.out_free = !result_valid || !result_stall;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.em_load || cmd.err_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      out_row <= xp_rd[EW-1 -: 8];
      out_col <= xp_rd[EW-9 -: 8];
      out_value <= 32'(xp_rd[SW-1:0]);
      status <= STATUS_OK;
      last_out <= stat.em_last;
    end else if (cmd.err_load) begin
      out_row <= '0;
      out_col <= '0;
      out_value <= '0;
      status <= err;
      last_out <= 1'b1;
    end
  end

`ifndef SYNTH
  // The store never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst) count <= NNZ_MAX)
    else $error("stft_dp: entry count above store depth");

  // An error word only goes out with a recorded error.
  assert property (@(posedge clk) disable iff (rst) cmd.err_load |-> err != STATUS_OK)
    else $error("stft_dp: error word without an error");

  // Scatter slots stay inside the filled part of the store.
  assert property (@(posedge clk) disable iff (rst) cmd.sc_write |-> cnt_rd < count)
    else $error("stft_dp: scatter slot out of range");
`endif

endmodule

FILE: rtl/core/sparse_triplet_fast_transpose.sv
// ----------------------------------------------------------------------------
// Sparse triplet fast transpose
// Collects a sparse matrix as (row, column, value) words and returns it
// transposed in column-major order.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (item_valid / item_stall) takes one triplet word, then
//   stalls while storing it; last_in marks the final word of a matrix. The
//   block stalls the input from the final word until its results are loaded
//   for output. After the final word, the prefix sum walks the column memory
//   over all min(MAX_COLS,256) entries, the scatter reads each stored entry,
//   then its column start, then writes it to the transposed store, and
//   emission reads each result and loads it when the output register is free.
//   An error (column at or above min(column_count,MAX_COLS), or more than
//   MAX_NNZ words) gives one word with a nonzero status, not the matrix.
//   The output register holds a result word while result_stall is high; the
//   last result may wait there while the next matrix is loaded.
//   The cfg channel writes column_count; it is always ready and is meant to
//   be written only while the block is idle.
//   Synchronous reset clears the control state and sets column_count to 256.
// ----------------------------------------------------------------------------
module sparse_triplet_fast_transpose
  import stft_pkg::*;
#(
  parameter int MAX_NNZ    = 64,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         row_index,
  input  logic [7:0]         col_index,
  input  logic signed [31:0] entry_value,
  input  logic               last_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last_out
);

  stft_cmd_t  cmd;
  stft_stat_t stat;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  stft_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath.
  stft_dp #(
    .MAX_NNZ    (MAX_NNZ),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .row_index    (row_index),
    .col_index    (col_index),
    .entry_value  (entry_value),
    .last_in      (last_in),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .status       (status),
    .last_out     (last_out)
  );

endmodule

FILE: verif/sparse_triplet_fast_transpose_tb.sv
// ----------------------------------------------------------------------------
// Sparse triplet fast transpose testbench
// Feeds matrices as triplet words with random gaps, predicts the transposed
// column-major output and the error words, and checks every result word
// field by field while the result side stalls at random and once for a long
// stretch.
// ----------------------------------------------------------------------------
module sparse_triplet_fast_transpose_tb
  import stft_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NNZ_DEPTH    = 64;
  localparam int COL_SPACE    = 256;
  localparam int SETTLE_TICKS = 700;
  localparam int HOLD_TICKS   = 900;
  localparam int ITEM_TARGET  = 370;

  // One stored source triplet.
  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
  } triplet_t;

  // One result word as the block should present it.
  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } result_word_t;

  // Tracks the matrix being loaded and the transposed words still owed.
  class transpose_predictor;
    logic [8:0]   column_count;
    triplet_t     loaded[$];
    logic [1:0]   first_error;
    result_word_t transposed_due[$];
    int           mismatches;
    int           words_seen;
    int           error_words;
    int           matrices;

    function new();
      column_count = 9'd256;
      first_error  = STATUS_OK;
      mismatches   = 0;
      words_seen   = 0;
      error_words  = 0;
      matrices     = 0;
    endfunction

    function int pending();
      return transposed_due.size();
    endfunction

    // Note one accepted triplet word; on the final word work out the matrix.
    function void take_triplet(logic [7:0] row, logic [7:0] col, logic [31:0] value,
                               logic last);
      int           lim;
      int           tally[COL_SPACE];
      int           start[COL_SPACE];
      result_word_t slots[NNZ_DEPTH];
      result_word_t word;
      int           pos;
      int           c;
      int           s;
      int           n;
      triplet_t     t;

      lim = (column_count > COL_SPACE) ? COL_SPACE : int'(column_count);
      if (int'(col) >= lim) begin
        if (first_error == STATUS_OK) first_error = STATUS_COL;
      end else if (loaded.size() >= NNZ_DEPTH) begin
        if (first_error == STATUS_OK) first_error = STATUS_NNZ;
      end else begin
        t.row = row;
        t.col = col;
        t.value = value;
        loaded.push_back(t);
      end
      if (!last) return;

      matrices++;
      if (first_error != STATUS_OK || loaded.size() == 0) begin
        word = '{row: 8'd0, col: 8'd0, value: 32'd0, status: first_error, last: 1'b1};
        transposed_due.push_back(word);
      end else begin
        // Count per column, then turn the counts into start slots.
        for (c = 0; c < COL_SPACE; c++) tally[c] = 0;
        foreach (loaded[i]) tally[loaded[i].col]++;
        pos = 0;
        for (c = 0; c < COL_SPACE; c++) begin
          start[c] = pos;
          pos += tally[c];
        end
        // Scatter in arrival order, which keeps each column stable.
        foreach (loaded[i]) begin
          s = start[loaded[i].col];
          start[loaded[i].col]++;
          slots[s] = '{row: loaded[i].col, col: loaded[i].row, value: loaded[i].value,
                       status: STATUS_OK, last: 1'b0};
        end
        n = loaded.size();
        for (s = 0; s < n; s++) begin
          slots[s].last = (s == n - 1);
          transposed_due.push_back(slots[s]);
        end
      end
      loaded.delete();
      first_error = STATUS_OK;
    endfunction

    // Compare one accepted result word with the oldest owed word.
    function void check_word(logic [7:0] row, logic [7:0] col, logic [31:0] value,
                             logic [1:0] stat, logic last);
      result_word_t want;

      words_seen++;
      if (transposed_due.size() == 0) begin
        $error("result word with nothing owed: row %0d col %0d value %h status %0d",
               row, col, value, stat);
        mismatches++;
        return;
      end
      want = transposed_due.pop_front();
      if (want.status != STATUS_OK) error_words++;
      if (row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, row);
        mismatches++;
      end
      if (col !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, col);
        mismatches++;
      end
      if (value !== want.value) begin
        $error("out_value: expected %h, got %h", want.value, value);
        mismatches++;
      end
      if (stat !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, stat);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_out: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [8:0]         cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [7:0]         row_index = '0;
  logic [7:0]         col_index = '0;
  logic signed [31:0] entry_value = '0;
  logic               last_in = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [7:0]         out_row;
  logic [7:0]         out_col;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic               last_out;

  transpose_predictor pred = new();
  logic [8:0] cur_count = 9'd256;
  int  words_sent = 0;
  int  settings_used = 0;
  bit  sender_quiet = 1'b0;
  bit  hold_request = 1'b0;
  int  holds_done = 0;

  sparse_triplet_fast_transpose dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .last_in     (last_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .status      (status),
    .last_out    (last_out)
  );

  always #5 clk = ~clk;

  // Watch both channels and feed the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        pred.take_triplet(row_index, col_index, entry_value, last_in);
      if (result_valid && !result_stall)
        pred.check_word(out_row, out_col, out_value, status, last_out);
    end
  end

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  function automatic int col_limit();
    return (cur_count > COL_SPACE) ? COL_SPACE : int'(cur_count);
  endfunction

  // Column inside the configured range, or above it when asked.
  function automatic logic [7:0] pick_col(bit out_of_range);
    int lim;
    lim = col_limit();
    if (out_of_range) return 8'($urandom_range(lim, 255));
    if ($urandom_range(0, 9) < 3) return 8'($urandom_range(0, (lim > 4) ? 3 : lim - 1));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h8000_0000;
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 14) return 32'h0000_0000;
    if (r < 18) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Offer one triplet word and hold it until taken.
  task automatic send_triplet(logic [7:0] row, logic [7:0] col, logic [31:0] value,
                              logic last);
    int gap;
    item_valid  <= 1'b1;
    row_index   <= row;
    col_index   <= col;
    entry_value <= value;
    last_in     <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every owed word, then let the block come fully to rest.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_column_count(logic [8:0] count);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred.column_count = count;
    cur_count = count;
    settings_used++;
  endtask

  // A short matrix of random words; out-of-range columns now and then.
  task automatic send_random_matrix(output int sent);
    int n;
    bit bad;
    n = $urandom_range(1, 12);
    sender_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      bad = (col_limit() == 0) || (col_limit() < COL_SPACE && $urandom_range(0, 99) < 4);
      send_triplet(8'($urandom), pick_col(bad), pick_value(), i == n - 1);
    end
    sender_quiet = 1'b0;
    sent = n;
  endtask

  // A long matrix: in-range words, then an optional out-of-range final word.
  task automatic send_long_matrix(int good, bit bad_tail);
    for (int i = 0; i < good; i++)
      send_triplet(8'($urandom), pick_col(1'b0), pick_value(),
                   !bad_tail && i == good - 1);
    if (bad_tail) send_triplet(8'($urandom), pick_col(1'b1), pick_value(), 1'b1);
  endtask

  // Result side: random stalls in changing moods, one long hold on request.
  initial begin
    int stall_pct;
    int mood_ticks;
    int hold_count;
    stall_pct = 0;
    mood_ticks = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_TICKS) begin
          @(posedge clk);
          hold_count++;
        end
        holds_done++;
        result_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < 2) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(15, 50)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
      mood_ticks++;
      if (mood_ticks >= 200) begin
        mood_ticks = 0;
        case ($urandom_range(0, 2))
          0: begin
            stall_pct = 0;
          end
          1: begin
            stall_pct = 20;
          end
          default: begin
            stall_pct = 50;
          end
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    logic [8:0] plan[8];
    logic [8:0] count;
    int phase;
    int phase_words;
    int sent;

    plan = '{9'd256, 9'd511, 9'd200, 9'd1, 9'd3, 9'd257, 9'd128, 9'd255};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at the reset column count, a stable column order.
    send_triplet(8'd255, 8'd255, 32'h7FFF_FFFF, 1'b1);
    send_triplet(8'd0, 8'd0, 32'h8000_0000, 1'b0);
    send_triplet(8'd3, 8'd5, 32'hFFFF_FFFF, 1'b0);
    send_triplet(8'd7, 8'd5, 32'h1234_5678, 1'b0);
    send_triplet(8'd2, 8'd0, 32'h0000_0001, 1'b0);
    send_triplet(8'd9, 8'd255, 32'h0000_0000, 1'b1);

    // Column out of range in mid-matrix, then the top legal column alone.
    write_column_count(9'd4);
    send_triplet(8'd1, 8'd2, 32'd5, 1'b0);
    send_triplet(8'd4, 8'd4, 32'd7, 1'b0);
    send_triplet(8'd6, 8'd1, 32'd3, 1'b1);
    send_triplet(8'd0, 8'd3, -32'sd5, 1'b1);

    // A single column, then a final word that misses it.
    write_column_count(9'd1);
    send_triplet(8'd10, 8'd0, 32'd1, 1'b0);
    send_triplet(8'd20, 8'd0, 32'd2, 1'b0);
    send_triplet(8'd30, 8'd0, 32'd3, 1'b1);
    send_triplet(8'd5, 8'd1, 32'd9, 1'b1);

    // No columns at all: every word is out of range.
    write_column_count(9'd0);
    send_triplet(8'd0, 8'd0, 32'd0, 1'b1);

    // Random phases across column counts, with the long matrices early on.
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      count = (phase < 8) ? plan[phase] : 9'($urandom_range(1, 256));
      write_column_count(count);
      if (phase == 0) send_long_matrix(NNZ_DEPTH, 1'b0);
      if (phase == 1) hold_request = 1'b1;
      if (phase == 2) begin
        // Overflow first, then a bad column; then both on the same word.
        send_long_matrix(NNZ_DEPTH + 1, 1'b1);
        send_long_matrix(NNZ_DEPTH, 1'b1);
      end
      phase_words = 0;
      while (phase_words < 24 && words_sent < ITEM_TARGET) begin
        send_random_matrix(sent);
        phase_words += sent;
      end
      phase++;
    end

    settle();
    if (pred.pending() != 0) begin
      $error("%0d result words never arrived", pred.pending());
      pred.mismatches++;
    end
    $display("Ran %0d matrices from %0d triplet words over %0d column counts.",
             pred.matrices, words_sent, settings_used + 1);
    $display("Checked %0d result words, %0d of them error words; %0d long holds.",
             pred.words_seen, pred.error_words, holds_done);
    if (pred.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sparse_triplet_fast_transpose.f
rtl/core/stft_pkg.sv
rtl/core/stft_ctrl.sv
rtl/core/stft_dp.sv
rtl/core/sparse_triplet_fast_transpose.sv
verif/sparse_triplet_fast_transpose_tb.sv
